// ===== rtl/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and constants of the squared distance transform block.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int COST_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int BOUND_BITS    = 50;

  typedef struct packed {
    logic                 operation;
    logic [COST_BITS-1:0] cost;
    logic                 last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] distance;
    logic        last_res;
    logic        empty_error;
  } out_word_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_ROWN,
    ST_P_RCOST,
    ST_P_MEET,
    ST_P_DIV,
    ST_Q_CHK,
    ST_Q_CMP,
    ST_Q_OWN,
    ST_Q_COST,
    ST_Q_SUM
  } state_t;

endpackage

// ===== rtl/sdt_div.sv =====
// ----------------------------------------------------------------------------
// sdt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdt_div #(
  parameter int DW = 49,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic          rem_nz
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dv_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign ge    = trial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? VW'(trial - {1'b0, dv_r}) : trial[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
  assign rem_nz   = rem_r != '0;

endmodule

// ===== rtl/squared_distance_transform_1d_top.sv =====
// ----------------------------------------------------------------------------
// squared_distance_transform_1d_top
// 1D squared distance transform by lower envelope of parabolas.
// ----------------------------------------------------------------------------
// Push: a first or dropped sample is taken in idle; any other sample reads the
//   top owner and bound, then its cost, then runs the divider on a dividend of
//   DW bits (49 by default), again per pop; the bit-serial divider sets the push rate.
// Pull: checks and compares one bound per segment passed, then reads the owner
//   and its cost and sums; error pulls are answered straight from idle.
// Reset clears pointers, lengths and flags; memories are not cleared.
module squared_distance_transform_1d_top #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdt_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sdt_pkg::out_word_t out_data
);

  localparam int CB = sdt_pkg::COST_BITS;
  localparam int FB = sdt_pkg::FRACTION_BITS;
  localparam int BB = sdt_pkg::BOUND_BITS;
  localparam int PW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int HW = ((CB > 2 * PW) ? CB : 2 * PW) + 1;
  localparam int DW = HW + FB;
  localparam int VW = PW + 1;
  localparam int SW = BB + 2;
  localparam logic signed [SW-1:0] B_HI = (SW'(1) <<< (BB - 1)) - SW'(2);
  localparam logic signed [SW-1:0] B_LO = SW'(1) - (SW'(1) <<< (BB - 1));

  sdt_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]        top_r, rs_r, pos_r, own_r;
  logic [CW-1:0]        len_r, rp_r;
  logic                 closed_r, last_r, neg_r;
  logic [HW-1:0]        hi_r;
  logic signed [BB-1:0] bnd_r;
  logic                 out_valid_r;
  sdt_pkg::out_word_t   out_r;

  logic [CB-1:0] cost_mem [MAX_LENGTH];
  logic [PW-1:0] own_mem  [MAX_LENGTH];
  logic [BB-1:0] bnd_mem  [MAX_LENGTH];
  logic [CB-1:0] cost_q;
  logic [PW-1:0] own_q;
  logic [BB-1:0] bnd_q;

  logic [PW-1:0] cost_ra, own_ra, bnd_ra;
  logic          cost_we, own_we, bnd_we;
  logic [PW-1:0] cost_wa, own_wa, bnd_wa;
  logic [PW-1:0] own_wd;
  logic [BB-1:0] bnd_wd;

  logic          acc, is_push, pull_err, pop;
  logic [CW-1:0] eff_len;
  logic          room;
  logic [HW-1:0] lo, mag;
  logic          div_start, div_done, rem_nz;
  logic [DW-1:0] quot;
  logic signed [SW-1:0] qs, sres;
  logic signed [BB-1:0] s;
  logic signed [BB-1:0] here;
  logic [PW-1:0] dq;
  logic [HW-1:0] sum;
  logic [31:0]   dist_sat;

  assign in_ready = (state_r == sdt_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign is_push  = in_data.operation == sdt_pkg::OP_PUSH;
  assign pull_err = !closed_r || (rp_r >= len_r);
  assign eff_len  = closed_r ? '0 : len_r;
  assign room     = eff_len < CW'(MAX_LENGTH);

  assign lo  = HW'(cost_q) + HW'(own_r * own_r);
  assign mag = (hi_r < lo) ? (lo - hi_r) : (hi_r - lo);

  always_comb begin
    qs = SW'(quot);
    if (neg_r) begin
      sres = -qs - (rem_nz ? SW'(1) : SW'(0));
    end else begin
      sres = qs;
    end
    if (sres < B_LO) sres = B_LO;
    if (sres > B_HI) sres = B_HI;
    s = sres[BB-1:0];
  end

  assign pop  = (top_r != '0) && (s <= bnd_r);
  assign here = BB'({rp_r, {FB{1'b0}}});
  assign dq   = (own_r > rp_r[PW-1:0]) ? (own_r - rp_r[PW-1:0]) : (rp_r[PW-1:0] - own_r);
  assign sum  = HW'(cost_q) + HW'(dq * dq);
  assign dist_sat = ((cost_q == {CB{1'b1}}) || (sum > HW'(32'hFFFF_FFFF))) ? 32'hFFFF_FFFF
                                                                            : sum[31:0];

  sdt_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag, {FB{1'b0}}}),
    .divisor  ({pos_r - own_r, 1'b0}),
    .done     (div_done),
    .quotient (quot),
    .rem_nz   (rem_nz)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdt_pkg::ST_IDLE: begin
        if (acc && is_push && room && (eff_len != '0)) state_nxt = sdt_pkg::ST_P_ROWN;
        else if (acc && !is_push && !pull_err) state_nxt = sdt_pkg::ST_Q_CHK;
      end
      sdt_pkg::ST_P_ROWN:  state_nxt = sdt_pkg::ST_P_RCOST;
      sdt_pkg::ST_P_RCOST: state_nxt = sdt_pkg::ST_P_MEET;
      sdt_pkg::ST_P_MEET:  state_nxt = sdt_pkg::ST_P_DIV;
      sdt_pkg::ST_P_DIV: begin
        if (div_done) state_nxt = pop ? sdt_pkg::ST_P_ROWN : sdt_pkg::ST_IDLE;
      end
      sdt_pkg::ST_Q_CHK: state_nxt = (rs_r < top_r) ? sdt_pkg::ST_Q_CMP : sdt_pkg::ST_Q_OWN;
      sdt_pkg::ST_Q_CMP: begin
        state_nxt = ($signed(bnd_q) < here) ? sdt_pkg::ST_Q_CHK : sdt_pkg::ST_Q_OWN;
      end
      sdt_pkg::ST_Q_OWN:  state_nxt = sdt_pkg::ST_Q_COST;
      sdt_pkg::ST_Q_COST: state_nxt = sdt_pkg::ST_Q_SUM;
      sdt_pkg::ST_Q_SUM:  state_nxt = sdt_pkg::ST_IDLE;
      default:            state_nxt = sdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cost_ra   = '0;
    own_ra    = '0;
    bnd_ra    = '0;
    cost_we   = 1'b0;
    cost_wa   = eff_len[PW-1:0];
    own_we    = 1'b0;
    own_wa    = '0;
    own_wd    = '0;
    bnd_we    = 1'b0;
    bnd_wa    = top_r + PW'(1);
    bnd_wd    = s;
    div_start = 1'b0;
    unique case (state_r)
      sdt_pkg::ST_IDLE: begin
        if (acc && is_push && room) begin
          cost_we = 1'b1;
          if (eff_len == '0) own_we = 1'b1;
        end
      end
      sdt_pkg::ST_P_ROWN: begin
        own_ra = top_r;
        bnd_ra = top_r;
      end
      sdt_pkg::ST_P_RCOST: cost_ra = own_q;
      sdt_pkg::ST_P_MEET:  div_start = 1'b1;
      sdt_pkg::ST_P_DIV: begin
        if (div_done && !pop) begin
          own_we = 1'b1;
          own_wa = top_r + PW'(1);
          own_wd = pos_r;
          bnd_we = 1'b1;
        end
      end
      sdt_pkg::ST_Q_CHK:  bnd_ra = rs_r + PW'(1);
      sdt_pkg::ST_Q_OWN:  own_ra = rs_r;
      sdt_pkg::ST_Q_COST: cost_ra = own_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= in_data.cost;
    if (own_we)  own_mem[own_wa]   <= own_wd;
    if (bnd_we)  bnd_mem[bnd_wa]   <= bnd_wd;
    cost_q <= cost_mem[cost_ra];
    own_q  <= own_mem[own_ra];
    bnd_q  <= bnd_mem[bnd_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdt_pkg::ST_IDLE;
      top_r       <= '0;
      len_r       <= '0;
      rp_r        <= '0;
      rs_r        <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (((state_r == sdt_pkg::ST_IDLE) && acc && !is_push && pull_err) ||
          (state_r == sdt_pkg::ST_Q_SUM)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        sdt_pkg::ST_IDLE: begin
          if (acc && is_push) begin
            if (room && (eff_len == '0)) begin
              top_r <= '0;
              len_r <= CW'(1);
            end
            if ((!room || (eff_len == '0)) && in_data.last) begin
              closed_r <= 1'b1;
              rp_r     <= '0;
              rs_r     <= '0;
            end else if (closed_r) begin
              closed_r <= 1'b0;
              rp_r     <= '0;
              rs_r     <= '0;
            end
          end
        end
        sdt_pkg::ST_P_DIV: begin
          if (div_done) begin
            if (pop) begin
              top_r <= top_r - PW'(1);
            end else begin
              top_r <= top_r + PW'(1);
              len_r <= len_r + CW'(1);
              if (last_r) begin
                closed_r <= 1'b1;
                rp_r     <= '0;
                rs_r     <= '0;
              end
            end
          end
        end
        sdt_pkg::ST_Q_CMP: begin
          if ($signed(bnd_q) < here) rs_r <= rs_r + PW'(1);
        end
        sdt_pkg::ST_Q_SUM: begin
          rp_r <= rp_r + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sdt_pkg::ST_IDLE && acc) begin
      pos_r  <= eff_len[PW-1:0];
      hi_r   <= HW'(in_data.cost) + HW'(eff_len[PW-1:0] * eff_len[PW-1:0]);
      last_r <= in_data.last;
      if (!is_push) out_r <= '{distance: 32'd0, last_res: 1'b0, empty_error: 1'b1};
    end
    if (state_r == sdt_pkg::ST_P_RCOST) begin
      own_r <= own_q;
      bnd_r <= $signed(bnd_q);
    end
    if (state_r == sdt_pkg::ST_Q_COST) own_r <= own_q;
    if (state_r == sdt_pkg::ST_P_MEET) neg_r <= hi_r < lo;
    if (state_r == sdt_pkg::ST_Q_SUM) begin
      out_r <= '{distance: dist_sat, last_res: (rp_r + CW'(1)) == len_r, empty_error: 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_top_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (CW'(top_r) < len_r))
    else $error("envelope top beyond line length");

  a_seg_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> (rs_r <= top_r))
    else $error("read segment beyond envelope top");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == sdt_pkg::ST_P_DIV))
    else $error("divider finished outside wait state");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdt_pkg::ST_Q_SUM) |-> !out_valid_r)
    else $error("result slot busy at pull completion");

endmodule
